[rtl/height_band_vote_router_macros.svh]
// Assertion macros shared by the height band vote router RTL.
`ifndef HEIGHT_BAND_VOTE_ROUTER_MACROS_SVH
`define HEIGHT_BAND_VOTE_ROUTER_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define HBVR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define HBVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hbvr_pkg.sv]
// Shared types and constants of the height band vote router.
`default_nettype none

package hbvr_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_BASE_DISTANCE     = 3'd0;
  localparam logic [2:0] REG_MAX_SAMPLES       = 3'd1;
  localparam logic [2:0] REG_BAND_A_LIMITS     = 3'd2;
  localparam logic [2:0] REG_BAND_B_LIMITS     = 3'd3;
  localparam logic [2:0] REG_BAND_C_LIMITS     = 3'd4;
  localparam logic [2:0] REG_ROUTE_TABLE       = 3'd5;
  localparam logic [2:0] REG_BLIND_MODE        = 3'd6;
  localparam logic [2:0] REG_STATION_POSITIONS = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  // Register reset values.
  localparam logic [11:0] RST_BASE_DISTANCE     = 12'd180;
  localparam logic [5:0]  RST_MAX_SAMPLES       = 6'd10;
  localparam logic [31:0] RST_BAND_A_LIMITS     = 32'd4456500;
  localparam logic [31:0] RST_BAND_B_LIMITS     = 32'd5767240;
  localparam logic [31:0] RST_BAND_C_LIMITS     = 32'd7077980;
  localparam logic [5:0]  RST_ROUTE_TABLE       = 6'd57;
  localparam logic        RST_BLIND_MODE        = 1'b0;
  localparam logic [47:0] RST_STATION_POSITIONS = 48'd5626461553040;

  // Verdict codes.
  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_TIE     = 2'd1;
  localparam logic [1:0] VERDICT_DISCARD = 2'd2;
  localparam logic [1:0] VERDICT_ROUTED  = 2'd3;

  // Class codes.
  localparam logic [1:0] CLASS_A = 2'd0;
  localparam logic [1:0] CLASS_B = 2'd1;
  localparam logic [1:0] CLASS_C = 2'd2;

  // Destination codes.
  localparam logic [1:0] DEST_DISCARD   = 2'd0;
  localparam logic [1:0] DEST_STATION_1 = 2'd1;
  localparam logic [1:0] DEST_STATION_2 = 2'd2;
  localparam logic [1:0] DEST_STATION_3 = 2'd3;

  localparam logic [16:0] SUM_MAX       = 17'h1FFFF;
  localparam logic [7:0]  ETA_DIVISOR   = 8'd100;
  // Products at or above 65536 * 100 give an ETA that saturates.
  localparam logic [31:0] ETA_SAT_LIMIT = 32'd6553600;
  localparam logic [15:0] ETA_MAX       = 16'hFFFF;

  // The ETA divisor as a rounded-up reciprocal; exact for any product below 2^23.
  localparam int          ETA_SHIFT = 30;
  localparam logic [23:0] ETA_RECIP =
      24'(((64'd1 << ETA_SHIFT) + 64'(ETA_DIVISOR) - 64'd1) / 64'(ETA_DIVISOR));

  // Restoring divider: one quotient bit per step over a 17-bit dividend.
  localparam int DIV_STEPS  = 17;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  // Queue between the sample front end and the verdict back end.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [11:0] base_distance;
    logic [5:0]  max_samples;
    logic [31:0] band_a_limits;
    logic [31:0] band_b_limits;
    logic [31:0] band_c_limits;
    logic [5:0]  route_table;
    logic        blind_mode;
    logic [47:0] station_positions;
  } cfg_t;

  // Accumulated state of one object, handed to the back end on its last item.
  typedef struct packed {
    logic [5:0]  votes_a;
    logic [5:0]  votes_b;
    logic [5:0]  votes_c;
    logic [16:0] height_sum;
    logic [5:0]  valid_count;
    logic [15:0] transit_ms;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_INIT,
    BK_DIV,
    BK_OUT
  } back_state_t;

  function automatic logic in_band(logic [11:0] h, logic [31:0] limits);
    logic [15:0] hw;
    hw = {4'd0, h};
    return (hw >= limits[15:0]) && (hw <= limits[31:16]);
  endfunction

endpackage

`default_nettype wire

[rtl/hbvr_front.sv]
// Sample front end: takes items, bins heights into bands and accumulates per object.
`default_nettype none

module hbvr_front import hbvr_pkg::*; #(
  parameter int SAMPLE_LIMIT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_distance_mm,
  input  wire logic        in_has_sample,
  input  wire logic        in_last,
  input  wire logic [15:0] in_transit_ms,
  input  wire q_status_t   q_status,
  output logic             q_push,
  output job_t             q_job
);

  localparam logic [6:0] LIMIT = 7'(SAMPLE_LIMIT);

  logic [5:0]  samples_r, samples_nxt;
  logic [5:0]  votes_a_r, votes_a_nxt;
  logic [5:0]  votes_b_r, votes_b_nxt;
  logic [5:0]  votes_c_r, votes_c_nxt;
  logic [16:0] sum_r, sum_nxt;
  logic [5:0]  count_r, count_nxt;

  logic        accept;
  logic [6:0]  limit;
  logic        take;
  logic        in_range;
  logic [11:0] height;
  logic        hit_a, hit_b, hit_c, hit;
  logic [17:0] sum_wide;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  always_comb begin
    limit    = ({1'b0, cfg.max_samples} > LIMIT) ? LIMIT : {1'b0, cfg.max_samples};
    take     = in_has_sample && ({1'b0, samples_r} < limit);
    in_range = in_distance_mm <= cfg.base_distance;
    height   = cfg.base_distance - in_distance_mm;
    // Bands are tried in order; the first one that holds the height wins.
    hit_a    = take && in_range && in_band(height, cfg.band_a_limits);
    hit_b    = take && in_range && !hit_a && in_band(height, cfg.band_b_limits);
    hit_c    = take && in_range && !hit_a && !hit_b && in_band(height, cfg.band_c_limits);
    hit      = hit_a || hit_b || hit_c;
    sum_wide = {1'b0, sum_r} + {6'd0, height};

    samples_nxt = take  ? samples_r + 6'd1 : samples_r;
    votes_a_nxt = hit_a ? votes_a_r + 6'd1 : votes_a_r;
    votes_b_nxt = hit_b ? votes_b_r + 6'd1 : votes_b_r;
    votes_c_nxt = hit_c ? votes_c_r + 6'd1 : votes_c_r;
    count_nxt   = hit   ? count_r + 6'd1   : count_r;
    if (!hit) begin
      sum_nxt = sum_r;
    end else if (sum_wide > {1'b0, SUM_MAX}) begin
      sum_nxt = SUM_MAX;
    end else begin
      sum_nxt = sum_wide[16:0];
    end
  end

  always_comb begin
    q_push            = accept && in_last;
    q_job.votes_a     = votes_a_nxt;
    q_job.votes_b     = votes_b_nxt;
    q_job.votes_c     = votes_c_nxt;
    q_job.height_sum  = sum_nxt;
    q_job.valid_count = count_nxt;
    q_job.transit_ms  = in_transit_ms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last)) begin
      samples_r <= '0;
      votes_a_r <= '0;
      votes_b_r <= '0;
      votes_c_r <= '0;
      sum_r     <= '0;
      count_r   <= '0;
    end else if (accept) begin
      samples_r <= samples_nxt;
      votes_a_r <= votes_a_nxt;
      votes_b_r <= votes_b_nxt;
      votes_c_r <= votes_c_nxt;
      sum_r     <= sum_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/hbvr_queue.sv]
// Short queue of finished objects between the front end and the back end.
`default_nettype none

module hbvr_queue import hbvr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire job_t  push_job,
  input  wire logic  pop,
  output job_t       pop_job,
  output q_status_t  status
);

  job_t            entry_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  always_comb begin
    status.full  = count_r == (Q_AW+1)'(Q_DEPTH);
    status.empty = count_r == '0;
    pop_job      = entry_r[rd_ptr_r];
    wr_ptr_nxt   = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt   = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

[rtl/hbvr_back.sv]
// Verdict back end: majority vote, routing, serial average and ETA scaling.
`default_nettype none

module hbvr_back import hbvr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire q_status_t q_status,
  input  wire job_t  q_job,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [1:0]  out_verdict,
  output logic [1:0]  out_box_class,
  output logic [1:0]  out_destination,
  output logic [1:0]  out_queue_station,
  output logic [11:0] out_average_height,
  output logic [15:0] out_eta_ms
);

  back_state_t state_r, state_nxt;

  job_t                  job_r;
  logic [1:0]            verdict_r;
  logic [1:0]            class_r;
  logic [1:0]            dest_r;
  logic [31:0]           prod_r;
  logic                  sat_r;
  logic [15:0]           eta_r;
  logic [5:0]            arem_r;
  logic [16:0]           adq_r;
  logic [DIV_STEP_W-1:0] step_r;

  logic       a_wins, b_wins, c_wins, winner;
  logic [1:0] cls;
  logic [1:0] dest;
  logic [1:0] verdict;
  logic [15:0] pos;
  logic [6:0] ash;
  logic       aq;
  logic [15:0] eta_q;
  logic       routed;

  // Vote, route and station selection from the popped object.
  always_comb begin
    a_wins = (job_r.votes_a > job_r.votes_b) && (job_r.votes_a > job_r.votes_c);
    b_wins = (job_r.votes_b > job_r.votes_a) && (job_r.votes_b > job_r.votes_c);
    c_wins = (job_r.votes_c > job_r.votes_a) && (job_r.votes_c > job_r.votes_b);
    winner = a_wins || b_wins || c_wins;
    if (b_wins) begin
      cls = CLASS_B;
    end else if (c_wins) begin
      cls = CLASS_C;
    end else begin
      cls = CLASS_A;
    end
    case (cls)
      CLASS_A: dest = cfg.route_table[1:0];
      CLASS_B: dest = cfg.route_table[3:2];
      CLASS_C: dest = cfg.route_table[5:4];
      default: dest = DEST_DISCARD;
    endcase
    if (!winner) begin
      dest = DEST_DISCARD;
    end
    if (job_r.valid_count == '0) begin
      verdict = VERDICT_NONE;
    end else if (!winner) begin
      verdict = VERDICT_TIE;
    end else if (dest == DEST_DISCARD) begin
      verdict = VERDICT_DISCARD;
    end else begin
      verdict = VERDICT_ROUTED;
    end
    case (dest)
      DEST_STATION_1: pos = cfg.station_positions[15:0];
      DEST_STATION_2: pos = cfg.station_positions[31:16];
      DEST_STATION_3: pos = cfg.station_positions[47:32];
      default:        pos = '0;
    endcase
  end

  // One restoring step of the average divider per cycle, and the ETA by reciprocal.
  always_comb begin
    ash = {arem_r, adq_r[16]};
    aq  = ash >= {1'b0, job_r.valid_count};
    // Below the saturation limit the product fits in 23 bits.
    eta_q = 16'(({24'd0, prod_r[22:0]} * {23'd0, ETA_RECIP}) >> ETA_SHIFT);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = BK_PREP;
        end
      end
      BK_PREP: state_nxt = BK_INIT;
      BK_INIT: state_nxt = BK_DIV;
      BK_DIV: begin
        if (step_r == DIV_STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_stall) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    routed             = verdict_r == VERDICT_ROUTED;
    q_pop              = (state_r == BK_IDLE) && !q_status.empty;
    out_valid          = state_r == BK_OUT;
    out_verdict        = verdict_r;
    out_box_class      = class_r;
    out_destination    = dest_r;
    out_queue_station  = !routed ? 2'd0 : (cfg.blind_mode ? dest_r : DEST_STATION_1);
    out_average_height = (verdict_r == VERDICT_NONE) ? 12'd0 : adq_r[11:0];
    if (routed && cfg.blind_mode) begin
      out_eta_ms = sat_r ? ETA_MAX : eta_r;
    end else begin
      out_eta_ms = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          job_r <= q_job;
        end
      end
      BK_PREP: begin
        verdict_r <= verdict;
        class_r   <= winner ? cls : CLASS_A;
        dest_r    <= dest;
        prod_r    <= pos * job_r.transit_ms;
      end
      BK_INIT: begin
        arem_r <= '0;
        adq_r  <= job_r.height_sum;
        eta_r  <= eta_q;
        sat_r  <= prod_r >= ETA_SAT_LIMIT;
        step_r <= '0;
      end
      BK_DIV: begin
        arem_r <= aq ? 6'(ash - {1'b0, job_r.valid_count}) : ash[5:0];
        adq_r  <= {adq_r[15:0], aq};
        step_r <= step_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/height_band_vote_router.sv]
// Top level of the height band vote router: configuration registers and block wiring.
`default_nettype none
`include "height_band_vote_router_macros.svh"

// Classifies a passing object from ultrasonic distance items and issues one
// verdict per object on its last item. The front end takes one input item
// every clock cycle while in_stall is low; on a last item it hands the
// object's vote counts and height sum to a two-entry queue. The back end
// turns each queued object into a result through its states in order: idle
// to pop, prep for the vote, route lookup and 16x16 station-position
// multiply, init to load the average divider and scale the product by the
// reciprocal of 100 into the ETA, 17 restoring-divider steps that produce
// the average height, and the output state, held while out_stall is high.
// Input stalls only while the queue holds two objects that wait for the
// back end, which takes no new object until its last result has left.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata and must only change while no object is in flight.
module height_band_vote_router import hbvr_pkg::*; #(
  parameter int SAMPLE_LIMIT = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [11:0]            in_distance_mm,
  input  wire logic                   in_has_sample,
  input  wire logic                   in_last,
  input  wire logic [15:0]            in_transit_ms,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  out_verdict,
  output logic [1:0]                  out_box_class,
  output logic [1:0]                  out_destination,
  output logic [1:0]                  out_queue_station,
  output logic [11:0]                 out_average_height,
  output logic [15:0]                 out_eta_ms
);

  cfg_t      cfg_r;
  q_status_t q_st;
  logic      q_push;
  logic      q_pop;
  job_t      push_job;
  job_t      pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_distance     <= RST_BASE_DISTANCE;
      cfg_r.max_samples       <= RST_MAX_SAMPLES;
      cfg_r.band_a_limits     <= RST_BAND_A_LIMITS;
      cfg_r.band_b_limits     <= RST_BAND_B_LIMITS;
      cfg_r.band_c_limits     <= RST_BAND_C_LIMITS;
      cfg_r.route_table       <= RST_ROUTE_TABLE;
      cfg_r.blind_mode        <= RST_BLIND_MODE;
      cfg_r.station_positions <= RST_STATION_POSITIONS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_DISTANCE:     cfg_r.base_distance     <= cfg_wdata[11:0];
        REG_MAX_SAMPLES:       cfg_r.max_samples       <= cfg_wdata[5:0];
        REG_BAND_A_LIMITS:     cfg_r.band_a_limits     <= cfg_wdata[31:0];
        REG_BAND_B_LIMITS:     cfg_r.band_b_limits     <= cfg_wdata[31:0];
        REG_BAND_C_LIMITS:     cfg_r.band_c_limits     <= cfg_wdata[31:0];
        REG_ROUTE_TABLE:       cfg_r.route_table       <= cfg_wdata[5:0];
        REG_BLIND_MODE:        cfg_r.blind_mode        <= cfg_wdata[0];
        REG_STATION_POSITIONS: cfg_r.station_positions <= cfg_wdata[47:0];
        default: begin
        end
      endcase
    end
  end

  hbvr_front #(
    .SAMPLE_LIMIT(SAMPLE_LIMIT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_distance_mm (in_distance_mm),
    .in_has_sample  (in_has_sample),
    .in_last        (in_last),
    .in_transit_ms  (in_transit_ms),
    .q_status       (q_st),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  hbvr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .status   (q_st)
  );

  hbvr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_status           (q_st),
    .q_job              (pop_job),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_verdict        (out_verdict),
    .out_box_class      (out_box_class),
    .out_destination    (out_destination),
    .out_queue_station  (out_queue_station),
    .out_average_height (out_average_height),
    .out_eta_ms         (out_eta_ms)
  );

  `HBVR_ASSERT_IMP(a_push_not_full, q_push, !q_st.full, "object pushed into a full queue")
  `HBVR_ASSERT_IMP(a_pop_not_empty, q_pop, !q_st.empty, "object popped from an empty queue")
  `HBVR_ASSERT_IMP(a_unrouted_quiet,
                   out_valid && out_verdict != VERDICT_ROUTED,
                   out_queue_station == 2'd0 && out_eta_ms == 16'd0,
                   "unrouted verdict carries a station or ETA")
  `HBVR_ASSERT_IMP(a_routed_dest,
                   out_valid && out_verdict == VERDICT_ROUTED,
                   out_destination != DEST_DISCARD && out_queue_station != 2'd0,
                   "routed verdict without a destination")
  `HBVR_ASSERT_IMP(a_sensor_no_eta, out_valid && !cfg_r.blind_mode, out_eta_ms == 16'd0,
                   "ETA given in sensor mode")

endmodule

`default_nettype wire
